// File: design/lru_page_replacement_unit_defines.svh
// Assertion helpers shared by the LRU page replacement RTL.
// Each one samples on clk_i and is disabled while rst_ni is low.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LRUPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lrupr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

  localparam int PAGE_W     = 8;
  localparam int FRAMES_W   = 4;
  localparam int FAULT_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [PAGE_W-1:0]   PAGE_RANGE_RST = 8'd10;
  localparam logic [FRAMES_W-1:0] FRAMES_RST     = 4'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES     = 1'b1;

  // Command from the control logic to the recency stack
  typedef struct packed {
    logic upd;    // commit a valid access this cycle
    logic evict;  // miss at or above the frame limit: drop the least-recent entry
  } stack_cmd_t;

  // Per-cell control from the stack to each cell
  typedef struct packed {
    logic upd;       // commit this cycle
    logic hit;       // access is a hit somewhere in the stack
    logic valid;     // cell holds a resident page
    logic miss_span; // cell lies in the range that shifts on a miss
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/lrupr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lrupr_cell #(
  parameter int PAGE_BITS = 8
) (
  input  wire                    clk_i,
  input  lrupr_pkg::cell_ctl_t   ctl_i,
  input  wire  [PAGE_BITS-1:0]   page_i,
  input  wire  [PAGE_BITS-1:0]   nbr_i,
  input  wire                    match_above_i,
  output logic                   match_o,
  output logic [PAGE_BITS-1:0]   entry_o
);
  import lrupr_pkg::*;

  logic [PAGE_BITS-1:0] entry_q;
  logic [PAGE_BITS-1:0] entry_d;
  logic                 take;

  // Match here or further toward the least-recent end; pages are unique.
  assign match_o = match_above_i || (ctl_i.valid && (entry_q == page_i));

  // On a hit, shift every cell up to the matching one; on a miss, the span.
  assign take    = ctl_i.upd && (ctl_i.hit ? match_o : ctl_i.miss_span);
  assign entry_d = nbr_i;

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: design/lrupr_stack.sv
`timescale 1ns / 1ps
`default_nettype none

module lrupr_stack #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 8
) (
  input  wire                                    clk_i,
  input  lrupr_pkg::stack_cmd_t                  cmd_i,
  input  wire  [PAGE_BITS-1:0]                   page_i,
  input  wire  [$clog2(MAX_FRAMES + 1)-1:0]      occ_i,
  output logic                                   hit_o,
  output logic [PAGE_BITS-1:0]                   victim_o
);
  import lrupr_pkg::*;

  localparam int OccW = $clog2(MAX_FRAMES + 1);

  logic [PAGE_BITS-1:0] entry [MAX_FRAMES];
  logic [PAGE_BITS-1:0] nbr   [MAX_FRAMES];
  logic [MAX_FRAMES:0]  sfx;
  logic [MAX_FRAMES-1:0] last;
  logic [OccW-1:0]      occ_e;
  cell_ctl_t            ctl [MAX_FRAMES];

  // Occupancy once the victim is gone; cells up to this index shift on a miss
  assign occ_e      = occ_i - OccW'(cmd_i.evict);
  assign sfx[MAX_FRAMES] = 1'b0;
  assign hit_o      = sfx[0];

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign nbr[g] = page_i;
    end else begin : g_body
      assign nbr[g] = entry[g-1];
    end

    assign ctl[g].upd       = cmd_i.upd;
    assign ctl[g].hit       = hit_o;
    assign ctl[g].valid     = OccW'(g) < occ_i;
    assign ctl[g].miss_span = OccW'(g) <= occ_e;
    assign last[g]          = OccW'(g + 1) == occ_i;

    lrupr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[g]),
      .page_i       (page_i),
      .nbr_i        (nbr[g]),
      .match_above_i(sfx[g+1]),
      .match_o      (sfx[g]),
      .entry_o      (entry[g])
    );
  end

  // Least-recent resident entry
  always_comb begin
    victim_o = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (last[i]) begin
        victim_o = victim_o | entry[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/lru_page_replacement_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lru_page_replacement_unit_defines.svh"

// LRU page replacement unit. Each page access is handled as it is accepted and its
// result appears in the output register on the next cycle, so a new access is
// accepted every cycle while the output side keeps up. The recency stack is a
// row of MAX_FRAMES cells, most recent first; every cell compares its page with
// the access in parallel and the hit flag ripples along the row, which sets the
// longest path. Pages 0 and above page_range are flagged out of range and leave
// all state alone. frames_in_use of 0 acts as 1; above MAX_FRAMES acts as
// MAX_FRAMES. Write configuration only while no access is in flight.
module lru_page_replacement_unit #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 8
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [lrupr_pkg::PAGE_W-1:0]          page_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic                                  out_of_range_o,
  output logic                                  hit_o,
  output logic                                  fault_o,
  output logic                                  evict_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]          evicted_page_o,
  output logic [lrupr_pkg::FAULT_W-1:0]         fault_total_o,
  output logic [lrupr_pkg::FRAMES_W-1:0]        frames_used_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [lrupr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [lrupr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import lrupr_pkg::*;

  localparam int OccW = $clog2(MAX_FRAMES + 1);
  localparam int CmpW = (OccW > FRAMES_W) ? OccW : FRAMES_W;

  logic [PAGE_W-1:0]   page_range_q;
  logic [FRAMES_W-1:0] frames_in_use_q;
  logic [OccW-1:0]     occ_q, occ_d;
  logic [FAULT_W-1:0]  fault_q, fault_d;

  logic                out_valid_q;
  logic                reject_q, hit_q, fault_flag_q, evict_q;
  logic [PAGE_W-1:0]   victim_q;
  logic [FAULT_W-1:0]  total_q;
  logic [FRAMES_W-1:0] used_q;

  logic                in_acc;
  logic                page_fits;
  logic                reject;
  logic                upd;
  logic                hit;
  logic                miss;
  logic                evict;
  logic [CmpW-1:0]     fiu_ext;
  logic [CmpW-1:0]     lim;
  logic [PAGE_BITS-1:0] page_w;
  logic [PAGE_BITS-1:0] victim;
  stack_cmd_t          cmd;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign page_w    = PAGE_BITS'(page_i);
  assign page_fits = PAGE_W'(page_w) == page_i;
  assign reject    = (page_i == '0) || (page_i > page_range_q) || !page_fits;
  assign upd       = in_acc && !reject;
  assign miss      = upd && !hit;

  // Clamp the frame limit to 1..MAX_FRAMES
  assign fiu_ext = CmpW'(frames_in_use_q);
  always_comb begin
    priority if (fiu_ext == '0) begin
      lim = CmpW'(1);
    end else if (fiu_ext > CmpW'(MAX_FRAMES)) begin
      lim = CmpW'(MAX_FRAMES);
    end else begin
      lim = fiu_ext;
    end
  end

  assign evict = miss && (CmpW'(occ_q) >= lim) && (occ_q != '0);

  assign cmd.upd   = upd;
  assign cmd.evict = evict;

  lrupr_stack #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_stack (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .page_i  (page_w),
    .occ_i   (occ_q),
    .hit_o   (hit),
    .victim_o(victim)
  );

  assign occ_d   = miss ? (occ_q - OccW'(evict) + OccW'(1)) : occ_q;
  assign fault_d = (miss && (fault_q != '1)) ? (fault_q + FAULT_W'(1)) : fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      fault_q <= '0;
    end else if (upd) begin
      occ_q   <= occ_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_range_q    <= PAGE_RANGE_RST;
      frames_in_use_q <= FRAMES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PAGE_RANGE: page_range_q    <= cfg_data_i;
        CFG_FRAMES:     frames_in_use_q <= cfg_data_i[FRAMES_W-1:0];
      endcase
    end
  end

  // Output register: advance on accept, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      reject_q     <= reject;
      hit_q        <= upd && hit;
      fault_flag_q <= miss;
      evict_q      <= evict;
      victim_q     <= evict ? PAGE_W'(victim) : '0;
      total_q      <= fault_d;
      used_q       <= FRAMES_W'(occ_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_of_range_o = reject_q;
  assign hit_o          = hit_q;
  assign fault_o        = fault_flag_q;
  assign evict_valid_o  = evict_q;
  assign evicted_page_o = victim_q;
  assign fault_total_o  = total_q;
  assign frames_used_o  = used_q;

  `LRUPR_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OccW'(MAX_FRAMES), "occupancy above frame count")
  `LRUPR_ASSERT_NOW(a_one_kind, out_valid_q, $onehot({reject_q, hit_q, fault_flag_q}),
    "result is not exactly one of reject, hit, fault")
  `LRUPR_ASSERT_NOW(a_evict_fault, out_valid_q && evict_q, fault_flag_q,
    "eviction without a fault")
  `LRUPR_ASSERT_NOW(a_victim_zero, out_valid_q && !evict_q, victim_q == '0,
    "evicted page nonzero without eviction")
  `LRUPR_ASSERT_NEXT(a_occ_hold, !miss, $stable(occ_q), "occupancy moved without a miss")

endmodule

`default_nettype wire

// File: sim/lru_page_replacement_unit_test.sv
`timescale 1ns / 1ps

module lru_page_replacement_unit_test;
  import lrupr_pkg::*;

  localparam int MAX_FRAMES = 8;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic                out_of_range;
    logic                hit;
    logic                fault;
    logic                evict_valid;
    logic [PAGE_W-1:0]   evicted_page;
    logic [FAULT_W-1:0]  fault_total;
    logic [FRAMES_W-1:0] frames_used;
  } access_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [PAGE_W-1:0]     page_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  out_of_range_o;
  logic                  hit_o;
  logic                  fault_o;
  logic                  evict_valid_o;
  logic [PAGE_W-1:0]     evicted_page_o;
  logic [FAULT_W-1:0]    fault_total_o;
  logic [FRAMES_W-1:0]   frames_used_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lru_page_replacement_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .page_i         (page_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_of_range_o (out_of_range_o),
    .hit_o          (hit_o),
    .fault_o        (fault_o),
    .evict_valid_o  (evict_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_total_o  (fault_total_o),
    .frames_used_o  (frames_used_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Predicted block state
  logic [PAGE_W-1:0]   lru_stack [MAX_FRAMES];
  int                  resident = 0;
  logic [FAULT_W-1:0]  fault_count = '0;
  logic [PAGE_W-1:0]   range_cfg = PAGE_RANGE_RST;
  logic [FRAMES_W-1:0] frames_cfg = FRAMES_RST;

  logic [PAGE_W-1:0] page_queue [$];
  logic [PAGE_W-1:0] recent_pages [$];
  access_result_t    expected_results [$];

  bit page_taken = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int n_accesses = 0;
  int n_hits = 0;
  int n_faults = 0;
  int n_evictions = 0;
  int n_rejects = 0;

  function automatic access_result_t lru_access(logic [PAGE_W-1:0] pg);
    access_result_t r;
    int limit;
    int pos;
    bit found;
    r = '0;
    found = 1'b0;
    pos = 0;
    limit = (frames_cfg == 0) ? 1 : (frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg);
    if (pg == 0 || pg > range_cfg) begin
      r.out_of_range = 1'b1;
    end else begin
      for (int i = 0; i < resident; i++) begin
        if (!found && lru_stack[i] == pg) begin
          found = 1'b1;
          pos = i;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        for (int i = pos; i > 0; i--) lru_stack[i] = lru_stack[i-1];
        lru_stack[0] = pg;
      end else begin
        r.fault = 1'b1;
        if (fault_count != '1) fault_count++;
        // Drop only the least-recent page, even if the limit was lowered further
        if (resident >= limit && resident > 0) begin
          r.evict_valid = 1'b1;
          r.evicted_page = lru_stack[resident-1];
          resident--;
        end
        for (int i = resident; i > 0; i--) begin
          if (i < MAX_FRAMES) lru_stack[i] = lru_stack[i-1];
        end
        lru_stack[0] = pg;
        if (resident < MAX_FRAMES) resident++;
      end
    end
    r.fault_total = fault_count;
    r.frames_used = resident[FRAMES_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  initial forever #4 clk_i = ~clk_i;

  // Page driver: hold the payload until the transaction is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || page_taken)) begin
      if (page_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        page_i <= page_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    access_result_t want;
    access_result_t seen;
    page_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        page_taken = 1'b1;
        want = lru_access(page_i);
        expected_results.push_back(want);
        n_accesses++;
        n_hits += int'(want.hit);
        n_faults += int'(want.fault);
        n_evictions += int'(want.evict_valid);
        n_rejects += int'(want.out_of_range);
      end
      if (out_valid_o && !out_stall_i) begin
        seen.out_of_range = out_of_range_o;
        seen.hit = hit_o;
        seen.fault = fault_o;
        seen.evict_valid = evict_valid_o;
        seen.evicted_page = evicted_page_o;
        seen.fault_total = fault_total_o;
        seen.frames_used = frames_used_o;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no access pending, got %p", $time, seen);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_of_range", 32'(want.out_of_range), 32'(seen.out_of_range));
          check_field("hit", 32'(want.hit), 32'(seen.hit));
          check_field("fault", 32'(want.fault), 32'(seen.fault));
          check_field("evict_valid", 32'(want.evict_valid), 32'(seen.evict_valid));
          check_field("evicted_page", 32'(want.evicted_page), 32'(seen.evicted_page));
          check_field("fault_total", want.fault_total, seen.fault_total);
          check_field("frames_used", 32'(want.frames_used), 32'(seen.frames_used));
        end
      end
    end
  end

  task automatic wait_idle();
    while (page_queue.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    if (idx == CFG_PAGE_RANGE) range_cfg = data;
    else frames_cfg = data[FRAMES_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_pages(logic [PAGE_W-1:0] pages [$]);
    foreach (pages[i]) page_queue.push_back(pages[i]);
  endtask

  // Mix of rejects, reuse of recent pages and fresh pages in range
  task automatic queue_random(int count);
    int r;
    logic [PAGE_W-1:0] pg;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 8) pg = '0;
      else if (r < 16) pg = PAGE_W'($urandom_range(255));
      else if (r < 60 && recent_pages.size() != 0)
        pg = recent_pages[$urandom_range(recent_pages.size() - 1)];
      else pg = PAGE_W'($urandom_range((range_cfg == 0) ? 1 : int'(range_cfg), 1));
      page_queue.push_back(pg);
      if (pg != 0) begin
        recent_pages.push_back(pg);
        if (recent_pages.size() > 12) void'(recent_pages.pop_front());
      end
    end
  endtask

  initial begin
    send_idle_pct = 21;
    recv_stall_pct = 74;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero frame limit acts as one frame
    write_reg(CFG_FRAMES, 8'd0);
    queue_pages('{8'd0, 8'd255, 8'd11, 8'd1, 8'd1, 8'd2, 8'd10});
    wait_idle();
    // Limit above the frame count acts as all frames
    write_reg(CFG_FRAMES, 8'd15);
    write_reg(CFG_PAGE_RANGE, 8'd255);
    queue_pages('{8'd255, 8'd128, 8'd127, 8'd85, 8'd170, 8'd1, 8'd2, 8'd3, 8'd255});
    wait_idle();
    // Lower the limit below occupancy
    write_reg(CFG_FRAMES, 8'd5);
    write_reg(CFG_PAGE_RANGE, 8'd10);
    queue_pages('{8'd4, 8'd3, 8'd0, 8'd11});
    wait_idle();

    write_reg(CFG_PAGE_RANGE, 8'd255);
    write_reg(CFG_FRAMES, 8'd8);
    queue_random(300);
    wait_idle();
    write_reg(CFG_PAGE_RANGE, 8'd20);
    write_reg(CFG_FRAMES, 8'd2);
    queue_random(250);
    wait_idle();

    send_idle_pct = 74;
    recv_stall_pct = 21;
    write_reg(CFG_PAGE_RANGE, 8'd3);
    write_reg(CFG_FRAMES, 8'd0);
    queue_random(150);
    wait_idle();
    write_reg(CFG_PAGE_RANGE, 8'd12);
    write_reg(CFG_FRAMES, 8'd15);
    queue_random(300);
    wait_idle();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Page range of zero rejects everything
    write_reg(CFG_PAGE_RANGE, 8'd0);
    write_reg(CFG_FRAMES, 8'd4);
    queue_random(40);
    wait_idle();
    // Upper data bits are dropped by the 4-bit frame register
    write_reg(CFG_PAGE_RANGE, 8'd16);
    write_reg(CFG_FRAMES, 8'hF3);
    hold_req = 1'b1;
    queue_random(300);
    wait_idle();
    write_reg(CFG_PAGE_RANGE, 8'd9);
    write_reg(CFG_FRAMES, 8'd5);
    queue_random(300);
    wait_idle();

    repeat (10) @(posedge clk_i);
    $display("Checked %0d accesses: %0d hits, %0d faults, %0d evictions, %0d rejected.",
             n_accesses, n_hits, n_faults, n_evictions, n_rejects);
    $display("Frame limits 0 to 15 and page ranges 0 to 255 applied, with a long output hold.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
